>>> rtl/crtf_pkg.sv
package crtf_pkg;

	// store capacity and derived widths
	localparam int MAX_TARGETS = 32;
	localparam int CNT_W       = $clog2(MAX_TARGETS + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// q16 range limit
	localparam logic signed [17:0] Q16_ONE = 18'sd65536;

	// answer codes
	typedef enum logic [2:0] {
		ST_READY    = 3'd0,
		ST_NONE     = 3'd1,
		ST_DISABLED = 3'd2,
		ST_INVALID  = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	// one stored target
	typedef struct packed {
		logic [1:0]  cls;
		logic [16:0] x;
		logic [16:0] y;
		logic [16:0] sc;
	} entry_t;

	// classified candidate as it travels through the queue
	typedef struct packed {
		entry_t ent;
		logic   invalid;
		logic   keep;
		logic   last;
		logic   disabled;
	} cand_t;

endpackage

>>> rtl/confidence_ranked_target_filter.sv
// Candidates are taken one per cycle while busy is low (start high, busy low).
// Each candidate is range checked and class filtered on entry, then goes through a
// four-deep queue to a register-based sorted store that inserts one candidate per
// cycle, so loading runs at one candidate per clock. With the queue empty, the final
// candidate gets its answer as follows: a single status item goes from the queue slot
// to the result register; a target list follows once the back end is in S_EMIT. A list
// gives the kept targets in descending score order, one per cycle on consecutive done
// strobes, with end_of_list on the last. While a list of n targets is being emitted the
// store is shifting and takes no new candidate, so up to four further candidates are
// queued and busy is then high until the queue has room. Results are valid for the single
// cycle that done is high; the receiver cannot stall them and must take each one as it
// comes. The class enable mask is written with cfg_write and should only change while
// idle.
module confidence_ranked_target_filter import crtf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  object_class,
	input  logic [17:0] pos_x,
	input  logic [17:0] pos_y,
	input  logic [17:0] score,
	input  logic        not_finite,
	input  logic        final_item,
	output logic        done,
	output logic [2:0]  status,
	output logic [1:0]  target_class,
	output logic [16:0] target_x,
	output logic [16:0] target_y,
	output logic [16:0] target_score,
	output logic        end_of_list
);

	logic  push;
	logic  pop;
	logic  queue_full;
	logic  queue_empty;
	cand_t push_data;
	cand_t pop_data;

	// candidate classification
	crtf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.start        (start),
		.object_class (object_class),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.score        (score),
		.not_finite   (not_finite),
		.final_item   (final_item),
		.queue_full   (queue_full),
		.busy         (busy),
		.push         (push),
		.push_data    (push_data)
	);

	// decoupling queue
	crtf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	// sorted store and answer output
	crtf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (queue_empty),
		.cand         (pop_data),
		.pop          (pop),
		.done         (done),
		.status       (status),
		.target_class (target_class),
		.target_x     (target_x),
		.target_y     (target_y),
		.target_score (target_score),
		.end_of_list  (end_of_list)
	);

endmodule

>>> rtl/crtf_front.sv
module crtf_front import crtf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_data,
	input  logic        start,
	input  logic [1:0]  object_class,
	input  logic [17:0] pos_x,
	input  logic [17:0] pos_y,
	input  logic [17:0] score,
	input  logic        not_finite,
	input  logic        final_item,
	input  logic        queue_full,
	output logic        busy,
	output logic        push,
	output cand_t       push_data
);

	logic [2:0] mask_q;
	logic [3:0] enable_vec;
	logic       in_range;

	// class enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_write) begin
			mask_q <= cfg_data;
		end
	end

	// range check and class selection
	always_comb begin
		in_range = ($signed(pos_x) >= 18'sd0) && ($signed(pos_x) <= Q16_ONE) &&
		           ($signed(pos_y) >= 18'sd0) && ($signed(pos_y) <= Q16_ONE) &&
		           ($signed(score) >= 18'sd0) && ($signed(score) <= Q16_ONE);
		enable_vec = {1'b0, mask_q};
		push_data.ent.cls = object_class;
		push_data.ent.x   = pos_x[16:0];
		push_data.ent.y   = pos_y[16:0];
		push_data.ent.sc  = score[16:0];
		push_data.invalid  = not_finite || !in_range;
		push_data.keep     = !push_data.invalid && enable_vec[object_class];
		push_data.last     = final_item;
		push_data.disabled = (mask_q == 3'd0);
	end

	// transaction accept
	assign busy = queue_full;
	assign push = start && !queue_full;

endmodule

>>> rtl/crtf_queue.sv
module crtf_queue import crtf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cand_t push_data,
	input  logic  pop,
	output cand_t pop_data,
	output logic  full,
	output logic  empty
);

	cand_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;

	assign full     = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/crtf_back.sv
module crtf_back import crtf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  cand_t       cand,
	output logic        pop,
	output logic        done,
	output logic [2:0]  status,
	output logic [1:0]  target_class,
	output logic [16:0] target_x,
	output logic [16:0] target_y,
	output logic [16:0] target_score,
	output logic        end_of_list
);

	typedef enum logic {
		S_LOAD,
		S_EMIT
	} state_t;

	state_t           state_q;
	entry_t           store_q [MAX_TARGETS];
	entry_t           ins_store [MAX_TARGETS];
	logic [MAX_TARGETS-1:0] ge;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] remain_q;
	logic             inv_q;
	logic             ovf_q;
	logic             store_full;
	logic             do_insert;
	logic             inv_n;
	logic             ovf_n;
	logic [CNT_W-1:0] cnt_n;

	assign pop        = (state_q == S_LOAD) && !empty;
	assign store_full = (cnt_q == CNT_W'(MAX_TARGETS));
	assign do_insert  = pop && cand.keep && !store_full;
	assign inv_n      = inv_q || cand.invalid;
	assign ovf_n      = ovf_q || (cand.keep && store_full);
	assign cnt_n      = do_insert ? cnt_q + 1'b1 : cnt_q;

	// insertion point: entries at or above the new score stay, the rest move down
	for (genvar p = 0; p < MAX_TARGETS; p++) begin : g_slot
		assign ge[p] = (CNT_W'(p) < cnt_q) && (store_q[p].sc >= cand.ent.sc);
		if (p == 0) begin : g_head
			assign ins_store[p] = ge[p] ? store_q[p] : cand.ent;
		end else begin : g_rest
			assign ins_store[p] = ge[p] ? store_q[p] :
			                      (ge[p-1] ? cand.ent : store_q[p-1]);
		end
	end

	// sorted store: insert while loading, shift toward the head while emitting
	always_ff @(posedge clk) begin
		if (do_insert) begin
			store_q <= ins_store;
		end else if (state_q == S_EMIT) begin
			for (int p = 0; p < MAX_TARGETS - 1; p++) begin
				store_q[p] <= store_q[p+1];
			end
		end
	end

	// set tracking, answer selection and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			cnt_q        <= '0;
			remain_q     <= '0;
			inv_q        <= 1'b0;
			ovf_q        <= 1'b0;
			done         <= 1'b0;
			status       <= ST_READY;
			target_class <= '0;
			target_x     <= '0;
			target_y     <= '0;
			target_score <= '0;
			end_of_list  <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (pop) begin
						if (!cand.last) begin
							cnt_q <= cnt_n;
							inv_q <= inv_n;
							ovf_q <= ovf_n;
						end else begin
							cnt_q        <= '0;
							inv_q        <= 1'b0;
							ovf_q        <= 1'b0;
							target_class <= '0;
							target_x     <= '0;
							target_y     <= '0;
							target_score <= '0;
							end_of_list  <= 1'b1;
							if (cand.disabled) begin
								done   <= 1'b1;
								status <= ST_DISABLED;
							end else if (inv_n) begin
								done   <= 1'b1;
								status <= ST_INVALID;
							end else if (ovf_n) begin
								done   <= 1'b1;
								status <= ST_OVERFLOW;
							end else if (cnt_n == '0) begin
								done   <= 1'b1;
								status <= ST_NONE;
							end else begin
								remain_q <= cnt_n;
								state_q  <= S_EMIT;
							end
						end
					end
				end
				S_EMIT: begin
					done         <= 1'b1;
					status       <= ST_READY;
					target_class <= store_q[0].cls;
					target_x     <= store_q[0].x;
					target_y     <= store_q[0].y;
					target_score <= store_q[0].sc;
					end_of_list  <= (remain_q == CNT_W'(1));
					remain_q     <= remain_q - 1'b1;
					if (remain_q == CNT_W'(1)) begin
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

>>> sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import crtf_pkg::*;

	// one candidate as offered to the block
	typedef struct packed {
		logic [1:0]         cls;
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] sc;
		logic               nf;
		logic               fin;
	} cand_item_t;

	// one answer item as emitted by the block
	typedef struct packed {
		status_t     st;
		logic [1:0]  cls;
		logic [16:0] x;
		logic [16:0] y;
		logic [16:0] sc;
		logic        eol;
	} answer_t;

	// ranks kept candidates and checks each answer item against the oldest expectation
	class ranked_target_checker;
		answer_t     expected_answers[$];
		entry_t      ranked_store[MAX_TARGETS];
		int          kept_num;
		bit          saw_invalid;
		bit          saw_overflow;
		logic [2:0]  class_mask;
		int          mismatches;
		int          checked;
		int          status_seen[5];

		function new();
			kept_num = 0;
			saw_invalid = 1'b0;
			saw_overflow = 1'b0;
			class_mask = 3'd0;
			mismatches = 0;
			checked = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void set_mask(logic [2:0] m);
			class_mask = m;
		endfunction

		function bit in_unit(logic signed [17:0] v);
			return (v >= 18'sd0) && (v <= Q16_ONE);
		endfunction

		// append one expected answer item at the tail
		function void enqueue_answer(answer_t a);
			expected_answers = {expected_answers, a};
		endfunction

		function void push_status(status_t st);
			answer_t a;
			a = '0;
			a.st = st;
			a.eol = 1'b1;
			enqueue_answer(a);
		endfunction

		function void note_candidate(cand_item_t c);
			int      p;
			int      k;
			answer_t a;
			// range check first, then class filter and ordered insert
			if (c.nf || !in_unit(c.x) || !in_unit(c.y) || !in_unit(c.sc)) begin
				saw_invalid = 1'b1;
			end else if (c.cls != 2'd3 && ((class_mask >> c.cls) & 3'd1) != 3'd0) begin
				if (kept_num >= MAX_TARGETS) begin
					saw_overflow = 1'b1;
				end else begin
					p = 0;
					while (p < kept_num && ranked_store[p].sc >= c.sc[16:0]) p++;
					for (k = kept_num; k > p; k--) ranked_store[k] = ranked_store[k - 1];
					ranked_store[p].cls = c.cls;
					ranked_store[p].x = c.x[16:0];
					ranked_store[p].y = c.y[16:0];
					ranked_store[p].sc = c.sc[16:0];
					kept_num++;
				end
			end
			if (!c.fin) return;
			// answer for the set, status precedence as specified
			if (class_mask == 3'd0) begin
				push_status(ST_DISABLED);
			end else if (saw_invalid) begin
				push_status(ST_INVALID);
			end else if (saw_overflow) begin
				push_status(ST_OVERFLOW);
			end else if (kept_num == 0) begin
				push_status(ST_NONE);
			end else begin
				for (k = 0; k < kept_num; k++) begin
					a.st = ST_READY;
					a.cls = ranked_store[k].cls;
					a.x = ranked_store[k].x;
					a.y = ranked_store[k].y;
					a.sc = ranked_store[k].sc;
					a.eol = (k == kept_num - 1);
					enqueue_answer(a);
				end
			end
			kept_num = 0;
			saw_invalid = 1'b0;
			saw_overflow = 1'b0;
		endfunction

		function void check_target(answer_t got);
			answer_t want;
			checked++;
			if (got.st <= ST_OVERFLOW) status_seen[int'(got.st)]++;
			if (expected_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected answer item: st=%0d cls=%0d x=%0d y=%0d sc=%0d eol=%0d",
						got.st, got.cls, got.x, got.y, got.sc, got.eol);
				return;
			end
			want = expected_answers.pop_front();
			if (got.st !== want.st || got.cls !== want.cls || got.x !== want.x ||
				got.y !== want.y || got.sc !== want.sc || got.eol !== want.eol) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch at %0t: expected st=%0d cls=%0d x=%0d y=%0d sc=%0d eol=%0d",
						$realtime, want.st, want.cls, want.x, want.y, want.sc, want.eol);
					$display("                  got st=%0d cls=%0d x=%0d y=%0d sc=%0d eol=%0d",
						got.st, got.cls, got.x, got.y, got.sc, got.eol);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [2:0]  cfg_data;
	logic        start;
	logic        busy;
	logic [1:0]  object_class;
	logic [17:0] pos_x;
	logic [17:0] pos_y;
	logic [17:0] score;
	logic        not_finite;
	logic        final_item;
	logic        done;
	logic [2:0]  status;
	logic [1:0]  target_class;
	logic [16:0] target_x;
	logic [16:0] target_y;
	logic [16:0] target_score;
	logic        end_of_list;

	ranked_target_checker tracker = new();
	int items_sent = 0;
	int sets_sent = 0;

	confidence_ranked_target_filter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.object_class (object_class),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.score        (score),
		.not_finite   (not_finite),
		.final_item   (final_item),
		.done         (done),
		.status       (status),
		.target_class (target_class),
		.target_x     (target_x),
		.target_y     (target_y),
		.target_score (target_score),
		.end_of_list  (end_of_list)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// answer monitor, one transaction per done strobe
	always @(posedge clk) begin
		answer_t got;
		if (arst_n && done) begin
			got.st = status_t'(status);
			got.cls = target_class;
			got.x = target_x;
			got.y = target_y;
			got.sc = target_score;
			got.eol = end_of_list;
			tracker.check_target(got);
		end
	end

	function automatic cand_item_t mk(logic [1:0] cls, int x, int y, int sc, bit nf, bit fin);
		cand_item_t c;
		c.cls = cls;
		c.x = 18'(x);
		c.y = 18'(y);
		c.sc = 18'(sc);
		c.nf = nf;
		c.fin = fin;
		return c;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// in-range q16 value with the ends favored
	function automatic logic signed [17:0] unit_value();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 18'sd0;
		if (r == 1) return 18'sd65536;
		return 18'($urandom_range(0, 65536));
	endfunction

	// out-of-range q16 value, above one or negative
	function automatic logic signed [17:0] bad_value();
		if ($urandom_range(0, 1)) return 18'($urandom_range(65537, 131071));
		return 18'($urandom_range(0, 131071)) | 18'h20000;
	endfunction

	function automatic cand_item_t rand_cand(bit clean, bit allow_drop, bit fin);
		cand_item_t c;
		c.cls = (allow_drop && $urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		c.x = unit_value();
		c.y = unit_value();
		// a coarse score grid makes ties common
		if ($urandom_range(0, 3) == 0)
			c.sc = 18'($urandom_range(0, 4) * 16384);
		else
			c.sc = unit_value();
		c.nf = 1'b0;
		c.fin = fin;
		if (!clean && $urandom_range(0, 4) == 0) begin
			case ($urandom_range(0, 3))
				0: c.nf = 1'b1;
				1: c.x = bad_value();
				2: c.y = bad_value();
				default: c.sc = bad_value();
			endcase
		end
		return c;
	endfunction

	// offer one candidate, start stays high after acceptance for back-to-back items
	task automatic send_candidate(cand_item_t c, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		object_class <= c.cls;
		pos_x <= c.x;
		pos_y <= c.y;
		score <= c.sc;
		not_finite <= c.nf;
		final_item <= c.fin;
		@(posedge clk);
		while (busy) @(posedge clk);
		tracker.note_candidate(c);
		items_sent++;
		if (c.fin) sets_sent++;
	endtask

	// hold off until every expected answer is in, then let the queue drain
	task automatic wait_for_answers();
		start <= 1'b0;
		while (tracker.expected_answers.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_class_mask(logic [2:0] m);
		cfg_write <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_write <= 1'b0;
		tracker.set_mask(m);
	endtask

	// stimulus
	initial begin
		cand_item_t c;
		int         set_len;
		bit         long_set;
		bit         clean;
		bit         burst;
		bit         mid_change;
		int         i;

		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_data = 3'd0;
		start = 1'b0;
		object_class = 2'd0;
		pos_x = '0;
		pos_y = '0;
		score = '0;
		not_finite = 1'b0;
		final_item = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// mask still zero after reset: disabled
		send_candidate(mk(2'd0, 0, 0, 0, 0, 1), gap_len());

		// classes 0 to 2 on, single target at the upper ends
		wait_for_answers();
		write_class_mask(3'd7);
		send_candidate(mk(2'd2, 65536, 65536, 65536, 0, 1), gap_len());

		// equal scores keep arrival order
		send_candidate(mk(2'd1, 0, 0, 0, 0, 0), gap_len());
		send_candidate(mk(2'd0, 100, 200, 65536, 0, 0), gap_len());
		send_candidate(mk(2'd2, 5, 5, 65536, 0, 0), gap_len());
		send_candidate(mk(2'd1, 7, 7, 0, 0, 1), gap_len());

		// negative x poisons the set
		send_candidate(mk(2'd0, -1, 300, 400, 0, 0), gap_len());
		send_candidate(mk(2'd1, 10, 20, 30, 0, 1), gap_len());

		// class 3 is dropped, leaving nothing
		send_candidate(mk(2'd3, 10, 20, 30, 0, 1), gap_len());

		// only class 1 enabled, others dropped
		wait_for_answers();
		write_class_mask(3'd2);
		send_candidate(mk(2'd0, 1, 2, 3, 0, 0), gap_len());
		send_candidate(mk(2'd2, 4, 5, 6, 0, 1), gap_len());

		// out-of-range values, also on a class that is not enabled
		send_candidate(mk(2'd1, 65537, 0, 0, 0, 0), gap_len());
		send_candidate(mk(2'd1, 9, 9, 9, 0, 1), gap_len());
		send_candidate(mk(2'd0, 0, 0, -131072, 0, 1), gap_len());
		send_candidate(mk(2'd1, 50, 60, 70, 1, 1), gap_len());
		send_candidate(mk(2'd1, 50, 131071, 70, 0, 1), gap_len());

		// mask changed inside a set: disabled judged at the final candidate
		send_candidate(mk(2'd1, 11, 12, 13, 0, 0), gap_len());
		wait_for_answers();
		write_class_mask(3'd0);
		send_candidate(mk(2'd1, 14, 15, 16, 0, 1), gap_len());

		// mask changed inside a set: each candidate filtered by its own mask
		wait_for_answers();
		write_class_mask(3'd1);
		send_candidate(mk(2'd0, 21, 22, 40000, 0, 0), gap_len());
		wait_for_answers();
		write_class_mask(3'd4);
		send_candidate(mk(2'd0, 23, 24, 50000, 0, 0), gap_len());
		send_candidate(mk(2'd2, 25, 26, 45000, 0, 1), gap_len());

		// random sets: mostly short, some medium, a few filling or overflowing the store
		while (items_sent < 370) begin
			long_set = ($urandom_range(0, 9) == 0);
			if (long_set)
				set_len = $urandom_range(0, 1) ? MAX_TARGETS : $urandom_range(33, 40);
			else if ($urandom_range(0, 3) == 0)
				set_len = $urandom_range(7, 16);
			else
				set_len = $urandom_range(1, 6);
			clean = long_set ? ($urandom_range(0, 2) != 0) : ($urandom_range(0, 9) < 7);
			burst = ($urandom_range(0, 4) == 0);
			if (long_set) begin
				wait_for_answers();
				write_class_mask(3'd7);
			end else if ($urandom_range(0, 3) == 0) begin
				wait_for_answers();
				write_class_mask($urandom_range(0, 1) ? 3'd7 : 3'($urandom_range(0, 7)));
			end else if ($urandom_range(0, 7) == 0) begin
				wait_for_answers();
			end
			mid_change = !long_set && set_len > 1 && ($urandom_range(0, 9) == 0);
			for (i = 0; i < set_len; i++) begin
				if (mid_change && i == set_len / 2) begin
					wait_for_answers();
					write_class_mask(3'($urandom_range(0, 7)));
				end
				c = rand_cand(clean, !long_set, i == set_len - 1);
				send_candidate(c, burst ? 0 : gap_len());
			end
		end

		wait_for_answers();
		$display("covered %0d candidates in %0d sets, %0d answer items checked",
			items_sent, sets_sent, tracker.checked);
		$display("answers by status: ready %0d, none %0d, disabled %0d, invalid %0d, overflow %0d",
			tracker.status_seen[0], tracker.status_seen[1], tracker.status_seen[2],
			tracker.status_seen[3], tracker.status_seen[4]);
		if (tracker.mismatches == 0 && tracker.expected_answers.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", tracker.mismatches);
			$display("FAILURE");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("timeout with %0d answer items outstanding", tracker.expected_answers.size());
		$display("FAILURE");
		$finish;
	end

endmodule

>>> filelist.f
rtl/crtf_pkg.sv
rtl/crtf_front.sv
rtl/crtf_queue.sv
rtl/crtf_back.sv
rtl/confidence_ranked_target_filter.sv
sim/testbench.sv
